>>> rtl/fspm_pkg.sv
// ----------------------------------------------------------------------------
// fspm_pkg: shared types and constants of the sine-PWM modulator
// Field widths, fixed-point formats, register indexes, the quarter-wave
// sine table and the sine/cosine table lookup helper.
// ----------------------------------------------------------------------------
package fspm_pkg;

    // Angle and duty resolution
    localparam int ANGLE_BITS = 12;
    localparam int DUTY_BITS  = 8;
    localparam int FRAC_BITS  = ANGLE_BITS - 6;
    localparam int SEG_W      = 5;

    // Field and register widths
    localparam int V_W        = 14;
    localparam int PP_W       = 7;
    localparam int ZERO_W     = 12;
    localparam int TRQ_W      = 16;

    // Phase voltages are held in units of 2^-30 of the 1/256 V step
    localparam int U_SHIFT    = 30;
    localparam int FULL_W     = V_W + U_SHIFT;
    localparam int SUM_W      = 48;
    localparam int SQRT3_Q14  = 28378;
    localparam int Q14_ONE    = 16384;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO   = 2'd3;

    // Reset values
    localparam logic [V_W-1:0]  SUPPLY_RST = 14'd3072;
    localparam logic [PP_W-1:0] POLES_RST  = 7'd1;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]   mech_angle;
        logic signed [TRQ_W-1:0] torque_voltage;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_BITS-1:0]  duty_a;
        logic [DUTY_BITS-1:0]  duty_b;
        logic [DUTY_BITS-1:0]  duty_c;
        logic [ANGLE_BITS-1:0] elec_angle;
    } t_out_item;

    // Table lookup result for one sine evaluation
    typedef struct packed {
        logic [14:0]          base;
        logic [10:0]          diff;
        logic [FRAC_BITS-1:0] frac;
        logic                 neg;
    } t_sin_part;

    // Quarter-wave sine, Q14, 16 segments
    function automatic logic [14:0] qwave(input logic [SEG_W-1:0] idx);
        logic [14:0] r;
        case (idx)
            5'd0:    r = 15'd0;
            5'd1:    r = 15'd1606;
            5'd2:    r = 15'd3196;
            5'd3:    r = 15'd4756;
            5'd4:    r = 15'd6270;
            5'd5:    r = 15'd7723;
            5'd6:    r = 15'd9102;
            5'd7:    r = 15'd10394;
            5'd8:    r = 15'd11585;
            5'd9:    r = 15'd12665;
            5'd10:   r = 15'd13623;
            5'd11:   r = 15'd14449;
            5'd12:   r = 15'd15137;
            5'd13:   r = 15'd15679;
            5'd14:   r = 15'd16069;
            5'd15:   r = 15'd16305;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

    // Fold the angle into the first quadrant and look up the segment
    function automatic t_sin_part sin_split(input logic [ANGLE_BITS-1:0] ang);
        t_sin_part             p;
        logic [ANGLE_BITS-3:0] pos;
        logic [ANGLE_BITS-2:0] xq;
        logic [SEG_W-1:0]      seg;
        pos = ang[ANGLE_BITS-3:0];
        if (ang[ANGLE_BITS-2]) begin
            xq = (ANGLE_BITS-1)'(1 << (ANGLE_BITS - 2)) - {1'b0, pos};
        end else begin
            xq = {1'b0, pos};
        end
        seg    = xq[ANGLE_BITS-2:FRAC_BITS];
        p.frac = xq[FRAC_BITS-1:0];
        p.neg  = ang[ANGLE_BITS-1];
        p.base = qwave(seg);
        if (seg >= SEG_W'(16)) begin
            p.diff = '0;
        end else begin
            p.diff = 11'(qwave(SEG_W'(seg + 1'b1)) - qwave(seg));
        end
        return p;
    endfunction

endpackage

>>> rtl/fspm_duty_div.sv
// ----------------------------------------------------------------------------
// fspm_duty_div: pipelined duty divider
// Scales a clamped phase voltage by the full duty count and divides it by
// the supply, one quotient bit per register stage (restoring division).
// ----------------------------------------------------------------------------
module fspm_duty_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [fspm_pkg::FULL_W-1:0]      i_volt,
    input  logic [fspm_pkg::V_W-1:0]         i_supply,
    output logic [fspm_pkg::DUTY_BITS-1:0]   o_duty
);
    import fspm_pkg::*;

    localparam int N_W = FULL_W + DUTY_BITS;

    logic [N_W-1:0]       r_rem [DUTY_BITS];
    logic [DUTY_BITS-1:0] r_quo [DUTY_BITS+1];

    // Form the numerator: voltage times (2^DUTY_BITS - 1)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {i_volt, {DUTY_BITS{1'b0}}} - N_W'(i_volt);
            r_quo[0] <= '0;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < DUTY_BITS; k++) begin : g_bit
        logic [N_W-1:0] dsh;
        logic [N_W:0]   trial;
        assign dsh   = N_W'(i_supply) << (U_SHIFT + DUTY_BITS - 1 - k);
        assign trial = {1'b0, r_rem[k]} - {1'b0, dsh};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= {r_quo[k][DUTY_BITS-2:0], ~trial[N_W]};
            end
        end

        if (k < DUTY_BITS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= trial[N_W] ? r_rem[k] : trial[N_W-1:0];
                end
            end
        end
    end

    assign o_duty = r_quo[DUTY_BITS];

endmodule

>>> rtl/foc_sine_pwm_modulator_core.sv
// ----------------------------------------------------------------------------
// foc_sine_pwm_modulator_core: sine-PWM stage of a field-oriented drive
// Electrical angle, command clamp, inverse Park (Ud = 0), inverse Clarke,
// half-supply offset, phase clamp and duty conversion, fully pipelined.
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_wr_en             | i_cfg_index, i_cfg_wdata
//
// One transfer is taken every cycle unless the output stalls; the pipeline is made of
// seven arithmetic stages and the bit-per-stage duty divider.
// A stall at a valid output freezes the whole pipeline; bubbles travel with it.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module foc_sine_pwm_modulator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fspm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fspm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [fspm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fspm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import fspm_pkg::*;

    localparam int LAT = 8 + DUTY_BITS;

    // Configuration registers
    logic [V_W-1:0]    r_supply;
    logic [PP_W-1:0]   r_poles;
    logic              r_dir;
    logic [ZERO_W-1:0] r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= SUPPLY_RST;
            r_poles  <= POLES_RST;
            r_dir    <= 1'b0;
            r_zero   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SUPPLY: r_supply <= i_cfg_wdata[V_W-1:0];
                CFG_POLES:  r_poles  <= i_cfg_wdata[PP_W-1:0];
                CFG_DIR:    r_dir    <= i_cfg_wdata[0];
                CFG_ZERO:   r_zero   <= i_cfg_wdata[ZERO_W-1:0];
                default:    ;
            endcase
        end
    end

    // Pipeline enable: advance unless the output holds an untaken result
    logic ce;
    assign ce         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !ce;

    logic                  r_vld  [LAT];
    logic [ANGLE_BITS-1:0] r_elec [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (ce) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // Stage 1: electrical angle and command clamp
    logic [ANGLE_BITS+PP_W-1:0] n_prod;
    logic [ANGLE_BITS-1:0]      n_scaled;
    logic signed [TRQ_W+1:0]    n_uq2w;
    logic signed [TRQ_W+1:0]    n_vs;
    logic signed [TRQ_W-1:0]    n_uq2;

    always_comb begin
        n_prod   = (ANGLE_BITS+PP_W)'(r_poles) * (ANGLE_BITS+PP_W)'(i_in_data.mech_angle);
        n_scaled = r_dir ? -n_prod[ANGLE_BITS-1:0] : n_prod[ANGLE_BITS-1:0];
        n_uq2w   = (TRQ_W+2)'(i_in_data.torque_voltage) <<< 1;
        n_vs     = (TRQ_W+2)'({1'b0, r_supply});
        if (n_uq2w > n_vs) begin
            n_uq2 = n_vs[TRQ_W-1:0];
        end else if (n_uq2w < -n_vs) begin
            n_uq2 = TRQ_W'(-n_vs);
        end else begin
            n_uq2 = n_uq2w[TRQ_W-1:0];
        end
    end

    logic signed [TRQ_W-1:0] r_uq2_1, r_uq2_2, r_uq2_3;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_elec[0] <= n_scaled - ANGLE_BITS'(r_zero);
            r_uq2_1   <= n_uq2;
            for (int i = 1; i < LAT; i++) r_elec[i] <= r_elec[i-1];
        end
    end

    // Stage 2: table lookup for sine and cosine
    t_sin_part r_sp, r_cp;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sp    <= sin_split(r_elec[0]);
            r_cp    <= sin_split(r_elec[0] + ANGLE_BITS'(1 << (ANGLE_BITS - 2)));
            r_uq2_2 <= r_uq2_1;
        end
    end

    // Stage 3: interpolate and apply the quadrant sign
    logic [10+FRAC_BITS:0] n_sfp, n_cfp;
    logic [14:0]           n_smag, n_cmag;
    logic signed [15:0]    r_sin, r_cos;

    always_comb begin
        n_sfp  = (11+FRAC_BITS)'(r_sp.diff) * (11+FRAC_BITS)'(r_sp.frac);
        n_cfp  = (11+FRAC_BITS)'(r_cp.diff) * (11+FRAC_BITS)'(r_cp.frac);
        n_smag = r_sp.base + 15'(n_sfp >> FRAC_BITS);
        n_cmag = r_cp.base + 15'(n_cfp >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sin   <= r_sp.neg ? -$signed({1'b0, n_smag}) : $signed({1'b0, n_smag});
            r_cos   <= r_cp.neg ? -$signed({1'b0, n_cmag}) : $signed({1'b0, n_cmag});
            r_uq2_3 <= r_uq2_2;
        end
    end

    // Stage 4: inverse Park, alpha = -Uq sin, beta = Uq cos
    logic signed [31:0] r_alpha, r_beta, r_alpha5;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_alpha <= -(32'(r_uq2_3) * 32'(r_sin));
            r_beta  <= 32'(r_uq2_3) * 32'(r_cos);
        end
    end

    // Stage 5: sqrt(3) times beta
    logic signed [SUM_W-1:0] r_pb;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pb     <= SUM_W'(SQRT3_Q14) * SUM_W'(r_beta);
            r_alpha5 <= r_alpha;
        end
    end

    // Stage 6: inverse Clarke plus half-supply offset
    logic signed [SUM_W-1:0] n_a48, n_half, n_full;
    logic signed [SUM_W-1:0] r_ua, r_ub, r_uc;

    always_comb begin
        n_a48  = SUM_W'(r_alpha5);
        n_half = SUM_W'(r_supply) <<< (U_SHIFT - 1);
        n_full = SUM_W'(r_supply) <<< U_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ua <= (n_a48 <<< 15) + n_half;
            r_ub <= r_pb - (n_a48 * SUM_W'(Q14_ONE)) + n_half;
            r_uc <= -(n_a48 * SUM_W'(Q14_ONE)) - r_pb + n_half;
        end
    end

    // Stage 7: clamp each phase to [0, supply]
    function automatic logic [FULL_W-1:0] clamp_u(input logic signed [SUM_W-1:0] u,
                                                  input logic signed [SUM_W-1:0] full);
        logic [FULL_W-1:0] r;
        if (u <= 0) begin
            r = '0;
        end else if (u > full) begin
            r = full[FULL_W-1:0];
        end else begin
            r = u[FULL_W-1:0];
        end
        return r;
    endfunction

    logic [FULL_W-1:0] r_ca, r_cb, r_cc;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ca <= clamp_u(r_ua, n_full);
            r_cb <= clamp_u(r_ub, n_full);
            r_cc <= clamp_u(r_uc, n_full);
        end
    end

    // Duty dividers, one per phase
    logic [DUTY_BITS-1:0] quo_a, quo_b, quo_c;

    fspm_duty_div u_div_a (
        .i_clk    (i_clk),
        .i_en     (ce),
        .i_volt   (r_ca),
        .i_supply (r_supply),
        .o_duty   (quo_a)
    );

    fspm_duty_div u_div_b (
        .i_clk    (i_clk),
        .i_en     (ce),
        .i_volt   (r_cb),
        .i_supply (r_supply),
        .o_duty   (quo_b)
    );

    fspm_duty_div u_div_c (
        .i_clk    (i_clk),
        .i_en     (ce),
        .i_volt   (r_cc),
        .i_supply (r_supply),
        .o_duty   (quo_c)
    );

    // Output: a zero supply drives every duty to zero
    logic zero_sup;
    assign zero_sup = (r_supply == '0);

    assign o_out_valid           = r_vld[LAT-1];
    assign o_out_data.duty_a     = zero_sup ? '0 : quo_a;
    assign o_out_data.duty_b     = zero_sup ? '0 : quo_b;
    assign o_out_data.duty_c     = zero_sup ? '0 : quo_c;
    assign o_out_data.elec_angle = r_elec[LAT-1];

endmodule
